// File: sv/brl_pkg.sv
// brl_pkg: types, constants and helpers for the bresenham line rasterizer
// used by brl_regs and bresenham_line_rasterizer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

	localparam int COORD_BITS     = 16;
	localparam int MAX_SCREEN_DIM = 4096;
	localparam int DIM_BITS       = 13;
	localparam int ADDR_BITS      = 24;
	localparam int COLOR_BITS     = 32;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;

	// command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(1024);
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(768);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS:0]          delta_t;
	typedef logic signed [COORD_BITS+1:0] err_t;
	typedef logic [DIM_BITS-1:0]          dim_t;

	typedef struct packed {
		logic                  command;
		coord_t                x_start;
		coord_t                y_start;
		coord_t                x_end;
		coord_t                y_end;
		logic [COLOR_BITS-1:0] line_color;
	} item_t;

	typedef struct packed {
		logic                  write_enable;
		coord_t                pixel_x;
		coord_t                pixel_y;
		logic [ADDR_BITS-1:0]  pixel_address;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  last;
		logic                  busy_res;
	} result_t;

	// effective screen size after clamping
	typedef struct packed {
		dim_t width;
		dim_t height;
	} screen_cfg_t;

	function automatic dim_t clamp_dim(input dim_t d);
		if (d > dim_t'(MAX_SCREEN_DIM)) begin
			return dim_t'(MAX_SCREEN_DIM);
		end
		return d;
	endfunction

	// true when coordinate c is at or beyond the far edge d
	function automatic logic at_or_beyond(input coord_t c, input dim_t d);
		logic signed [COORD_BITS:0] c_ext;
		logic signed [COORD_BITS:0] d_ext;
		c_ext = {c[COORD_BITS-1], c};
		d_ext = {{(COORD_BITS+1-DIM_BITS){1'b0}}, d};
		return c_ext >= d_ext;
	endfunction

	function automatic delta_t abs_diff(input coord_t a, input coord_t b);
		logic signed [COORD_BITS:0] diff;
		diff = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
		if (diff[COORD_BITS]) begin
			return delta_t'(-diff);
		end
		return delta_t'(diff);
	endfunction

endpackage

`default_nettype wire

// File: sv/bresenham_line_rasterizer.sv
// bresenham_line_rasterizer: top level, item register, bresenham walk and result register
// depends on brl_pkg and brl_regs
`timescale 1ns / 1ps
`default_nettype none

// usage
//  src channel carries commands: start (latches endpoints and color) or step.
//  res channel carries one pixel per step taken on an active line; starts,
//  rejected lines and steps while idle give nothing on res.
//  a transfer on either channel happens at a rising edge with valid high and
//  stall low.
//  a command transferred on src sits in the item register and is processed once
//  the result register can advance; its pixel is then held in the result register.
//  throughput: one command per cycle while res is not stalled, so one pixel per
//  clock on a run of steps; the bound is the error/coordinate update loop.
//  when res is stalled the result register and the item register hold, and
//  src_stall rises once the item register is full; nothing is dropped.
//  reset idles the walk, empties both registers and sets the screen to 1024 x 768.
//  the user must write screen size over apb while the block is idle (not enforced).
//  rejection uses the size at start, on-screen test and address the current one.
module bresenham_line_rasterizer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              src_valid,
	output logic                                   src_stall,
	input  wire brl_pkg::item_t                    src_data,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output brl_pkg::result_t                       res_data,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [brl_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [brl_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [brl_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                   pready
);
	import brl_pkg::*;

	screen_cfg_t screen;

	brl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.screen  (screen)
	);

	// item register
	logic  item_valid_s1;
	item_t item_s1;
	logic  advance;
	logic  accept;
	logic  fire;

	// walk state
	logic                  active_q;
	coord_t                cur_x_q;
	coord_t                cur_y_q;
	coord_t                goal_x_q;
	coord_t                goal_y_q;
	delta_t                delta_x_q;
	delta_t                delta_y_q;
	logic                  step_x_neg_q;
	logic                  step_y_neg_q;
	err_t                  err_q;
	logic [COLOR_BITS-1:0] color_q;

	// result register
	logic    res_valid_q;
	result_t res_q;

	// start setup
	delta_t start_dx;
	delta_t start_dy;
	logic   reject;

	// step logic
	logic                             is_start;
	logic                             is_step;
	logic                             on_screen;
	logic                             fin;
	logic signed [COORD_BITS+2:0]     e2;
	logic signed [COORD_BITS+2:0]     dx_ext;
	logic signed [COORD_BITS+2:0]     dy_ext;
	logic                             move_x;
	logic                             move_y;
	logic signed [COORD_BITS+2:0]     err_next;
	logic [2*DIM_BITS-1:0]            addr_prod;
	logic [2*DIM_BITS-1:0]            addr_sum;
	result_t                          res_next;

	assign advance   = !res_valid_q || !res_stall;
	assign src_stall = item_valid_s1 && !advance;
	assign accept    = src_valid && !src_stall;
	assign fire      = item_valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= src_data;
		end
	end

	assign is_start = fire && (item_s1.command == CMD_START);
	assign is_step  = fire && (item_s1.command == CMD_STEP) && active_q;

	assign start_dx = abs_diff(item_s1.x_start, item_s1.x_end);
	assign start_dy = abs_diff(item_s1.y_start, item_s1.y_end);
	assign reject   = (item_s1.x_start[COORD_BITS-1] && item_s1.x_end[COORD_BITS-1])
		|| (item_s1.y_start[COORD_BITS-1] && item_s1.y_end[COORD_BITS-1])
		|| (at_or_beyond(item_s1.x_start, screen.width)
			&& at_or_beyond(item_s1.x_end, screen.width))
		|| (at_or_beyond(item_s1.y_start, screen.height)
			&& at_or_beyond(item_s1.y_end, screen.height));

	assign on_screen = !cur_x_q[COORD_BITS-1] && !at_or_beyond(cur_x_q, screen.width)
		&& !cur_y_q[COORD_BITS-1] && !at_or_beyond(cur_y_q, screen.height);
	assign fin = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);

	assign e2       = {err_q, 1'b0};
	assign dx_ext   = {2'b00, delta_x_q};
	assign dy_ext   = {2'b00, delta_y_q};
	assign move_x   = e2 > -dy_ext;
	assign move_y   = e2 < dx_ext;
	assign err_next = {err_q[COORD_BITS+1], err_q}
		- (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);

	assign addr_prod = cur_y_q[DIM_BITS-1:0] * screen.width;
	assign addr_sum  = addr_prod + {{DIM_BITS{1'b0}}, cur_x_q[DIM_BITS-1:0]};

	always_comb begin
		res_next.write_enable  = on_screen;
		res_next.pixel_x       = cur_x_q;
		res_next.pixel_y       = cur_y_q;
		res_next.pixel_address = on_screen ? addr_sum[ADDR_BITS-1:0] : '0;
		res_next.pixel_color   = color_q;
		res_next.last          = fin;
		res_next.busy_res      = !fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (is_start) begin
			active_q <= !reject;
		end else if (is_step && fin) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			cur_x_q      <= item_s1.x_start;
			cur_y_q      <= item_s1.y_start;
			goal_x_q     <= item_s1.x_end;
			goal_y_q     <= item_s1.y_end;
			delta_x_q    <= start_dx;
			delta_y_q    <= start_dy;
			step_x_neg_q <= !(item_s1.x_start < item_s1.x_end);
			step_y_neg_q <= !(item_s1.y_start < item_s1.y_end);
			err_q        <= err_t'({1'b0, start_dx}) - err_t'({1'b0, start_dy});
			color_q      <= item_s1.line_color;
		end else if (is_step && !fin) begin
			err_q <= err_next[COORD_BITS+1:0];
			if (move_x) begin
				cur_x_q <= step_x_neg_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
			end
			if (move_y) begin
				cur_y_q <= step_y_neg_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= is_step;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_step) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_offscreen_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.write_enable |-> res_data.pixel_address == '0)
		else $error("off-screen pixel with nonzero address");

	a_start_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		is_start |=> !res_valid)
		else $error("start command produced a result");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		is_step && fin |=> !active_q && res_valid && res_data.last)
		else $error("walk still active after last pixel");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> item_valid_s1 && res_valid_q)
		else $error("input stalled with no held item");

	a_idle_step_no_state: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.command == CMD_STEP && !active_q |=> !res_valid && !active_q)
		else $error("step while idle changed the walk");

endmodule

`default_nettype wire

// File: sv/brl_regs.sv
// brl_regs: apb register file holding the screen width and height
// depends on brl_pkg
`timescale 1ns / 1ps
`default_nettype none

module brl_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [brl_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [brl_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [brl_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                   pready,
	output brl_pkg::screen_cfg_t                   screen
);
	import brl_pkg::*;

	dim_t width_q;
	dim_t height_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_SCREEN_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
				REG_SCREEN_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_SCREEN_WIDTH:  prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, width_q};
			REG_SCREEN_HEIGHT: prdata = {{(APB_DATA_BITS-DIM_BITS){1'b0}}, height_q};
			default:           prdata = '0;
		endcase
	end

	assign screen.width  = clamp_dim(width_q);
	assign screen.height = clamp_dim(height_q);

endmodule

`default_nettype wire

// File: bench/bresenham_line_rasterizer_test.sv
// bresenham_line_rasterizer_test: self-checking bench for the line rasterizer top level
// needs brl_pkg and bresenham_line_rasterizer; its own pixel predictor checks every transfer
`timescale 1ns / 1ps

module bresenham_line_rasterizer_test;
	import brl_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 265;
	localparam int PHASES          = 6;
	localparam int DRAIN_CYCLES    = 6;
	localparam int HOLD_CYCLES     = 300;
	localparam int PLAN_ROWS       = 25;

	typedef struct {
		item_t   it;
		bit      typed;
		bit      gives;
		result_t px;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	item_t src_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	result_t res_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	// predictor state
	bit line_on;
	int at_x, at_y, to_x, to_y, span_x, span_y, err_acc;
	bit x_dec, y_dec;
	logic [COLOR_BITS-1:0] ink;
	dim_t scr_w = WIDTH_RESET;
	dim_t scr_h = HEIGHT_RESET;

	result_t pixel_expect_q [$];
	int errors = 0;
	int pixels_seen = 0;
	int lines_started = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int run_phase = -1;
	bit hold_done = 1'b0;
	int src_idle_pct = 22;
	int res_idle_pct = 84;

	bresenham_line_rasterizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int screen_span(input dim_t d);
		return (int'(d) > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : int'(d);
	endfunction

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic item_t start_cmd(input int x0, input int y0, input int x1, input int y1,
			input logic [COLOR_BITS-1:0] color);
		item_t it;
		it.command    = CMD_START;
		it.x_start    = coord_t'(x0);
		it.y_start    = coord_t'(y0);
		it.x_end      = coord_t'(x1);
		it.y_end      = coord_t'(y1);
		it.line_color = color;
		return it;
	endfunction

	// endpoint and color fields are don't-care on a step, so they carry noise
	function automatic item_t step_cmd();
		item_t it;
		it = start_cmd(int'($urandom), int'($urandom), int'($urandom), int'($urandom), $urandom);
		it.command = CMD_STEP;
		return it;
	endfunction

	function automatic result_t pix(input bit we, input int x, input int y, input int addr,
			input logic [COLOR_BITS-1:0] color, input bit fin);
		result_t p;
		p.write_enable  = we;
		p.pixel_x       = coord_t'(x);
		p.pixel_y       = coord_t'(y);
		p.pixel_address = ADDR_BITS'(addr);
		p.pixel_color   = color;
		p.last          = fin;
		p.busy_res      = !fin;
		return p;
	endfunction

	function automatic string pix_text(input result_t p);
		return $sformatf("we=%0b x=%0d y=%0d addr=%h color=%h last=%0b busy=%0b",
			p.write_enable, $signed(p.pixel_x), $signed(p.pixel_y), p.pixel_address,
			p.pixel_color, p.last, p.busy_res);
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	// advances the walk for one command; returns 1 when a pixel transfer is due
	function automatic bit trace_pixel(input item_t it, output result_t px);
		int w, h, x0, y0, x1, y1, e2;
		bit on_scr, at_goal;
		w = screen_span(scr_w);
		h = screen_span(scr_h);
		px = '0;
		if (it.command == CMD_START) begin
			x0 = $signed(it.x_start);
			y0 = $signed(it.y_start);
			x1 = $signed(it.x_end);
			y1 = $signed(it.y_end);
			line_on = 1'b0;
			if ((x0 < 0 && x1 < 0) || (y0 < 0 && y1 < 0) ||
					(x0 >= w && x1 >= w) || (y0 >= h && y1 >= h)) begin
				return 1'b0;
			end
			at_x = x0;
			at_y = y0;
			to_x = x1;
			to_y = y1;
			span_x = magnitude(x1 - x0);
			span_y = magnitude(y1 - y0);
			x_dec = !(x0 < x1);
			y_dec = !(y0 < y1);
			err_acc = span_x - span_y;
			ink = it.line_color;
			line_on = 1'b1;
			return 1'b0;
		end
		if (!line_on) begin
			return 1'b0;
		end
		on_scr = at_x >= 0 && at_x < w && at_y >= 0 && at_y < h;
		at_goal = at_x == to_x && at_y == to_y;
		px = pix(on_scr, at_x, at_y, on_scr ? at_y * w + at_x : 0, ink, at_goal);
		if (at_goal) begin
			line_on = 1'b0;
		end else begin
			e2 = 2 * err_acc;
			if (e2 > -span_y) begin
				err_acc -= span_y;
				at_x += x_dec ? -1 : 1;
			end
			if (e2 < span_x) begin
				err_acc += span_x;
				at_y += y_dec ? -1 : 1;
			end
		end
		return 1'b1;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input item_t it, input bit typed = 1'b0,
			input bit typed_gives = 1'b0, input result_t typed_px = '0);
		result_t px;
		bit gives;
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_data <= it;
		do @(posedge clk); while (src_stall);
		items_sent++;
		gives = trace_pixel(it, px);
		if (typed) begin
			gives = typed_gives;
			px = typed_px;
		end
		if (gives) begin
			pixel_expect_q.push_back(px);
		end
		if (it.command == CMD_START && line_on) begin
			lines_started++;
		end
		@(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic idx,
			input logic [APB_DATA_BITS-1:0] wdata, output logic [APB_DATA_BITS-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_screen(input logic idx, input dim_t v);
		logic [APB_DATA_BITS-1:0] rd;
		apb_access(1'b1, idx, {(APB_DATA_BITS-DIM_BITS)'($urandom), v}, rd);
		if (idx == REG_SCREEN_WIDTH) begin
			scr_w = v;
		end else begin
			scr_h = v;
		end
		apb_access(1'b0, idx, '0, rd);
		if (rd !== APB_DATA_BITS'(v)) begin
			flag_error($sformatf("register %0d reads %h, expected %h", idx, rd, v));
		end
	endtask

	task automatic quiesce();
		src_valid <= 1'b0;
		while (pixel_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly short lines around the screen, some long, some cut off or overrun
	task automatic draw_random_line();
		int w, h, reach, x0, y0, x1, y1, pixels, steps;
		w = screen_span(scr_w);
		h = screen_span(scr_h);
		reach = ($urandom_range(9) == 0) ? 300 : 24;
		x0 = int'($urandom_range(w + 16)) - 8;
		y0 = int'($urandom_range(h + 16)) - 8;
		x1 = x0 + int'($urandom_range(2 * reach)) - reach;
		y1 = y0 + int'($urandom_range(2 * reach)) - reach;
		pixels = magnitude(x1 - x0);
		if (magnitude(y1 - y0) > pixels) begin
			pixels = magnitude(y1 - y0);
		end
		pixels++;
		case ($urandom_range(9))
			0, 1: begin
				steps = $urandom_range(pixels - 1);
			end
			2: begin
				steps = pixels + 1 + $urandom_range(2);
			end
			default: begin
				steps = pixels;
			end
		endcase
		send_item(start_cmd(x0, y0, x1, y1, $urandom));
		repeat (steps) send_item(step_cmd());
	endtask

	task automatic send_noise();
		if ($urandom_range(1) == 1) begin
			send_item(start_cmd(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
				$urandom));
			repeat ($urandom_range(6)) send_item(step_cmd());
		end else begin
			send_item(step_cmd());
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		string bad;
		if (arst_n && res_valid && !res_stall) begin
			pixels_seen++;
			if (pixel_expect_q.size() == 0) begin
				flag_error($sformatf("unexpected pixel %s", pix_text(res_data)));
			end else begin
				want = pixel_expect_q.pop_front();
				bad = "";
				if (res_data.write_enable !== want.write_enable) bad = {bad, " write_enable"};
				if (res_data.pixel_x !== want.pixel_x) bad = {bad, " pixel_x"};
				if (res_data.pixel_y !== want.pixel_y) bad = {bad, " pixel_y"};
				if (res_data.pixel_address !== want.pixel_address) bad = {bad, " pixel_address"};
				if (res_data.pixel_color !== want.pixel_color) bad = {bad, " pixel_color"};
				if (res_data.last !== want.last) bad = {bad, " last"};
				if (res_data.busy_res !== want.busy_res) bad = {bad, " busy_res"};
				if (bad != "") begin
					flag_error($sformatf("pixel mismatch on%s: expected %s, got %s", bad,
						pix_text(want), pix_text(res_data)));
				end
			end
		end
	end

	// receiver side, with one long hold-off so the block backs up into src_stall
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run_phase == 4 && !hold_done) begin
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) begin
					res_stall <= 1'b1;
					@(negedge clk);
				end
			end
			res_stall <= ($urandom_range(99) < res_idle_pct);
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
			pixel_expect_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		plan_row_t plan [PLAN_ROWS];
		dim_t phase_w [PHASES];
		dim_t phase_h [PHASES];
		int target;
		plan = '{
			'{step_cmd(), 1'b1, 1'b0, '0},
			'{start_cmd(0, 0, 0, 0, 32'hFFFF_FFFF), 1'b1, 1'b0, '0},
			'{step_cmd(), 1'b1, 1'b1, pix(1'b1, 0, 0, 0, 32'hFFFF_FFFF, 1'b1)},
			'{step_cmd(), 1'b1, 1'b0, '0},
			'{start_cmd(1023, 767, 1023, 767, 32'h0), 1'b1, 1'b0, '0},
			'{step_cmd(), 1'b1, 1'b1, pix(1'b1, 1023, 767, 24'hB_FFFF, 32'h0, 1'b1)},
			'{start_cmd(-5, 10, -1, 20, 32'h1111_1111), 1'b1, 1'b0, '0},
			'{step_cmd(), 1'b1, 1'b0, '0},
			'{start_cmd(1024, 0, 2000, 5, 32'h2222_2222), 1'b1, 1'b0, '0},
			'{start_cmd(3, -1, 7, -32768, 32'h3333_3333), 1'b1, 1'b0, '0},
			'{start_cmd(0, 768, 5, 32767, 32'h4444_4444), 1'b1, 1'b0, '0},
			'{start_cmd(-32768, -32768, 32767, 32767, 32'hA5A5_5A5A), 1'b1, 1'b0, '0},
			'{step_cmd(), 1'b1, 1'b1, pix(1'b0, -32768, -32768, 0, 32'hA5A5_5A5A, 1'b0)},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{start_cmd(10, 10, 5, 2, 32'h1234_5678), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{start_cmd(-2, 3, 2, 1, 32'h8000_0001), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0},
			'{start_cmd(0, 0, 1000, 300, 32'h00FF_00FF), 1'b0, 1'b0, '0},
			'{step_cmd(), 1'b0, 1'b0, '0}
		};
		phase_w = '{dim_t'(64), dim_t'(1), dim_t'(4096), dim_t'(8191), dim_t'(0), dim_t'($urandom)};
		phase_h = '{dim_t'(48), dim_t'(1), dim_t'(4096), dim_t'(0), dim_t'(8191), dim_t'($urandom)};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			send_item(plan[i].it, plan[i].typed, plan[i].gives, plan[i].px);
		end

		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			set_screen(REG_SCREEN_WIDTH, phase_w[p]);
			set_screen(REG_SCREEN_HEIGHT, phase_h[p]);
			if (p < 2) begin
				src_idle_pct = 22;
				res_idle_pct = 84;
			end else if (p < 4) begin
				src_idle_pct = 84;
				res_idle_pct = 22;
			end else begin
				src_idle_pct = 0;
				res_idle_pct = 0;
			end
			run_phase = p;
			// step any line left open across the size change
			repeat (4) send_item(step_cmd());
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				if ($urandom_range(99) < 75) begin
					draw_random_line();
				end else begin
					send_noise();
				end
			end
		end
		quiesce();

		$display("drew %0d lines and checked %0d pixels over %0d screen sizes, %0d errors",
			lines_started, pixels_seen, PHASES + 1, errors);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
